// ===== hdl/line_follow_steering_controller_macros.svh =====
// assertion helpers used by the checker in lfsc_chk.sv
`ifndef LINE_FOLLOW_STEERING_CONTROLLER_MACROS_SVH
`define LINE_FOLLOW_STEERING_CONTROLLER_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define LFSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LFSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lfsc_pkg.sv =====
`default_nettype none
package lfsc_pkg;

  localparam int unsigned SENSORS    = 15;
  localparam int unsigned ANGLE_W    = 9;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned GAIN_W     = 6;
  localparam int unsigned SPEED_W    = 7;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned WGT_W      = 5;
  localparam int unsigned WSUM_W     = 6;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned QUO_W      = 5;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned ERR_W      = 5;
  localparam int unsigned DIFF_W     = 6;
  localparam int unsigned SUM_W      = 13;
  localparam int unsigned PID_W      = 20;
  localparam int unsigned DRIVE_W    = 12;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned SLOPE_W    = 3;

  localparam int SUM_LIMIT       = 4095;
  localparam int DRIVE_LIMIT     = 2047;
  localparam int JUNCTION_THR    = 20;
  localparam int RECOVERY_BLACKS = 5;
  localparam int DOWNHILL_SHIFT  = 2;
  localparam int EDGE_ERR        = 8;

  localparam logic signed [ANGLE_W-1:0] PITCH_UP_LIM = 9'sd10;
  localparam logic signed [ANGLE_W-1:0] PITCH_DN_LIM = -9'sd10;
  localparam logic signed [ANGLE_W-1:0] ROLL_HI_LIM  = 9'sd6;
  localparam logic signed [ANGLE_W-1:0] ROLL_LO_LIM  = -9'sd6;

  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN   = 6'd15;
  localparam logic [GAIN_W-1:0]  RST_INT_GAIN    = 6'd0;
  localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN  = 6'd0;
  localparam logic [SPEED_W-1:0] RST_NORMAL_SPD  = 7'd40;
  localparam logic [SPEED_W-1:0] RST_FAST_SPD    = 7'd60;
  localparam logic [SPEED_W-1:0] RST_SLOW_SPD    = 7'd20;
  localparam logic [WIN_W-1:0]   RST_CREST_WIN   = 16'd2000;
  localparam logic [WIN_W-1:0]   RST_RECOV_WIN   = 16'd1500;

  typedef enum logic [ACT_W-1:0] {
    ACT_DRIVE    = 2'd0,
    ACT_RESCUE   = 2'd1,
    ACT_CREST    = 2'd2,
    ACT_RECOVERY = 2'd3
  } action_t;

  typedef enum logic [SLOPE_W-1:0] {
    SLOPE_LEVEL      = 3'd0,
    SLOPE_UP         = 3'd1,
    SLOPE_DOWN       = 3'd2,
    SLOPE_TILT_RIGHT = 3'd3,
    SLOPE_TILT_LEFT  = 3'd4
  } slope_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INT_GAIN    = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_NORMAL_SPD  = 3'd3,
    REG_FAST_SPD    = 3'd4,
    REG_SLOW_SPD    = 3'd5,
    REG_CREST_WIN   = 3'd6,
    REG_RECOV_WIN   = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHOOSE,
    ST_DIV,
    ST_MAC_P,
    ST_MAC_I,
    ST_MAC_D,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integral_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [SPEED_W-1:0] normal_speed;
    logic [SPEED_W-1:0] fast_speed;
    logic [SPEED_W-1:0] slow_speed;
    logic [WIN_W-1:0]   crest_window_ms;
    logic [WIN_W-1:0]   recovery_window_ms;
  } cfg_t;

  typedef struct packed {
    logic [SENSORS-1:0]        black_mask;
    logic                      silver_seen;
    logic                      front_black;
    logic signed [ANGLE_W-1:0] pitch_deg;
    logic signed [ANGLE_W-1:0] roll_deg;
    logic [TIME_W-1:0]         now_ms;
  } in_item_t;

  typedef struct packed {
    action_t                   action;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    slope_t                    slope_status;
    logic                      slope_changed;
  } out_item_t;

  typedef struct packed {
    logic                    en;
    logic                    clr;
    logic [GAIN_W-1:0]       gain;
    logic signed [SUM_W-1:0] operand;
  } mac_ctl_t;

  function automatic logic signed [WGT_W-1:0] sensor_weight(input logic [IDX_W-1:0] idx);
    logic signed [WGT_W-1:0] w;
    unique case (idx)
      4'd0:    w = -5'sd8;
      4'd1:    w = -5'sd6;
      4'd2:    w = -5'sd5;
      4'd3:    w = -5'sd4;
      4'd4:    w = -5'sd3;
      4'd5:    w = -5'sd2;
      4'd6:    w = -5'sd1;
      4'd7:    w = 5'sd0;
      4'd8:    w = 5'sd1;
      4'd9:    w = 5'sd2;
      4'd10:   w = 5'sd3;
      4'd11:   w = 5'sd4;
      4'd12:   w = 5'sd5;
      4'd13:   w = 5'sd6;
      4'd14:   w = 5'sd8;
      default: w = 5'sd0;
    endcase
    return w;
  endfunction

  function automatic logic signed [SUM_W-1:0] clamp_sum(input logic signed [SUM_W:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > (SUM_W+1)'(SUM_LIMIT)) begin
      r = SUM_W'(SUM_LIMIT);
    end else if (v < -(SUM_W+1)'(SUM_LIMIT)) begin
      r = -SUM_W'(SUM_LIMIT);
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DRIVE_W-1:0] clamp_drive(input logic signed [PID_W:0] v);
    logic signed [DRIVE_W-1:0] r;
    if (v > (PID_W+1)'(DRIVE_LIMIT)) begin
      r = DRIVE_W'(DRIVE_LIMIT);
    end else if (v < -(PID_W+1)'(DRIVE_LIMIT)) begin
      r = -DRIVE_W'(DRIVE_LIMIT);
    end else begin
      r = v[DRIVE_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/lfsc_if.sv =====
`default_nettype none
interface lfsc_in_if;
  import lfsc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [SENSORS-1:0]        black_mask;
  logic                      silver_seen;
  logic                      front_black;
  logic signed [ANGLE_W-1:0] pitch_deg;
  logic signed [ANGLE_W-1:0] roll_deg;
  logic [TIME_W-1:0]         now_ms;

  modport source (output valid, black_mask, silver_seen, front_black, pitch_deg,
                  roll_deg, now_ms, input ready);
  modport sink (input valid, black_mask, silver_seen, front_black, pitch_deg,
                roll_deg, now_ms, output ready);
endinterface

interface lfsc_out_if;
  import lfsc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [ACT_W-1:0]          action;
  logic signed [DRIVE_W-1:0] left_drive;
  logic signed [DRIVE_W-1:0] right_drive;
  logic [SLOPE_W-1:0]        slope_status;
  logic                      slope_changed;

  modport source (output valid, action, left_drive, right_drive, slope_status,
                  slope_changed, input ready);
  modport sink (input valid, action, left_drive, right_drive, slope_status,
                slope_changed, output ready);
endinterface
`default_nettype wire

// ===== hdl/line_follow_steering_controller.sv =====
// line follow steering controller
//
// in_ch carries one sensor frame per beat (valid/ready); out_ch returns
// exactly one result beat per frame, in order. cfg_we/cfg_index/cfg_wdata
// write one register per clock with no wait; write only while idle.
//
// a frame is worked by a small sequencer: a sensor scan over the fifteen
// sensors, a five-step restoring divider for the centroid, and one shared
// multiply-accumulate unit that forms the three pid terms in turn.
// a driving frame runs scan, choose, divide, the three pid steps and finish;
// rescue, crest and recovery frames skip the divide and pid after choose.
// in_ch.ready is high only between frames, so frames are taken one at a
// time, and a new frame waits until the last has left finish.
//
// results sit in an output register; a stalled receiver holds the beat and
// the next frame is still accepted and worked, finishing once it drains.
// synchronous reset restores register defaults, level slope, zero times
// and a cleared pid state, and drops both channels to idle.
`default_nettype none
module line_follow_steering_controller (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lfsc_in_if.sink                                in_ch,
  lfsc_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [lfsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lfsc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lfsc_pkg::*;

  cfg_t      cfg_r;
  in_item_t  in_item;
  out_item_t out_item;
  logic      in_ready, out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain          <= RST_PROP_GAIN;
      cfg_r.integral_gain      <= RST_INT_GAIN;
      cfg_r.deriv_gain         <= RST_DERIV_GAIN;
      cfg_r.normal_speed       <= RST_NORMAL_SPD;
      cfg_r.fast_speed         <= RST_FAST_SPD;
      cfg_r.slow_speed         <= RST_SLOW_SPD;
      cfg_r.crest_window_ms    <= RST_CREST_WIN;
      cfg_r.recovery_window_ms <= RST_RECOV_WIN;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:  cfg_r.prop_gain          <= cfg_wdata[GAIN_W-1:0];
        REG_INT_GAIN:   cfg_r.integral_gain      <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN: cfg_r.deriv_gain         <= cfg_wdata[GAIN_W-1:0];
        REG_NORMAL_SPD: cfg_r.normal_speed       <= cfg_wdata[SPEED_W-1:0];
        REG_FAST_SPD:   cfg_r.fast_speed         <= cfg_wdata[SPEED_W-1:0];
        REG_SLOW_SPD:   cfg_r.slow_speed         <= cfg_wdata[SPEED_W-1:0];
        REG_CREST_WIN:  cfg_r.crest_window_ms    <= cfg_wdata[WIN_W-1:0];
        REG_RECOV_WIN:  cfg_r.recovery_window_ms <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.black_mask  = in_ch.black_mask;
    in_item.silver_seen = in_ch.silver_seen;
    in_item.front_black = in_ch.front_black;
    in_item.pitch_deg   = in_ch.pitch_deg;
    in_item.roll_deg    = in_ch.roll_deg;
    in_item.now_ms      = in_ch.now_ms;
  end

  lfsc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.action        = out_item.action;
  assign out_ch.left_drive    = out_item.left_drive;
  assign out_ch.right_drive   = out_item.right_drive;
  assign out_ch.slope_status  = out_item.slope_status;
  assign out_ch.slope_changed = out_item.slope_changed;

endmodule
`default_nettype wire

// ===== hdl/lfsc_div.sv =====
`default_nettype none
module lfsc_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [lfsc_pkg::QUO_W-1:0] dividend,
  input  wire logic [lfsc_pkg::CNT_W-1:0] divisor,
  output logic      [lfsc_pkg::QUO_W-1:0] quotient,
  output logic                            done
);
  import lfsc_pkg::*;

  // restoring division, one quotient bit per cycle
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r;
  logic [CNT_W:0]    trial;
  logic              fits;

  always_comb begin
    trial   = {rem_r, quo_r[QUO_W-1]};
    fits    = trial >= {1'b0, divisor};
    rem_nxt = fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
    quo_nxt = {quo_r[QUO_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule
`default_nettype wire

// ===== hdl/lfsc_mac.sv =====
`default_nettype none
module lfsc_mac (
  input  wire logic                              clk,
  input  wire lfsc_pkg::mac_ctl_t                ctl,
  output logic signed [lfsc_pkg::PID_W-1:0]      acc
);
  import lfsc_pkg::*;

  logic signed [PID_W-1:0] acc_r, acc_nxt;
  logic signed [PID_W-1:0] gain_ext, op_ext, prod;

  always_comb begin
    gain_ext = {{(PID_W-GAIN_W){1'b0}}, ctl.gain};
    op_ext   = {{(PID_W-SUM_W){ctl.operand[SUM_W-1]}}, ctl.operand};
    prod     = gain_ext * op_ext;
    acc_nxt  = (ctl.clr ? '0 : acc_r) + prod;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

// ===== hdl/lfsc_seq.sv =====
`default_nettype none
module lfsc_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lfsc_pkg::cfg_t      cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lfsc_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lfsc_pkg::out_item_t      out_item
);
  import lfsc_pkg::*;

  state_t state_r, state_nxt;

  // persistent controller state
  slope_t                  slope_r;
  logic [TIME_W-1:0]       up_time_r, lvl_time_r;
  logic signed [SUM_W-1:0] err_sum_r;
  logic signed [ERR_W-1:0] prev_err_r;

  // per-frame working registers
  logic [SENSORS-1:0]       mask_r;
  logic                     silver_r, front_r, changed_r;
  logic                     crest_hit_r, recov_hit_r;
  logic [IDX_W-1:0]         idx_r;
  logic signed [WSUM_W-1:0] wsum_r;
  logic [CNT_W-1:0]         cnt_r;
  action_t                  act_r;
  logic signed [ERR_W-1:0]  err_r;
  logic [SPEED_W-1:0]       speed_r;

  out_item_t out_r;
  logic      out_valid_r;

  logic                     accept, out_load, div_start, div_done;
  logic [QUO_W-1:0]         quotient;
  mac_ctl_t                 mac_ctl;
  logic signed [PID_W-1:0]  acc;

  slope_t                   slope_new;
  logic [TIME_W-1:0]        dt_up, dt_lvl;
  action_t                  act_comb;
  logic [QUO_W-1:0]         wsum_abs;
  logic                     edge_l, edge_r, junction;
  logic signed [ERR_W-1:0]  err_div, err_fin;
  logic [ERR_W-1:0]         err_abs;
  logic [SPEED_W-1:0]       speed_fin;
  logic signed [SUM_W-1:0]  sum_new;
  logic signed [DIFF_W-1:0] err_diff;
  logic signed [PID_W-1:0]  turn, acc_bias;
  logic signed [PID_W:0]    left_full, right_full, speed_ext, turn_ext;
  out_item_t                result;

  // slope classification and window checks at the accepting edge
  always_comb begin
    if (in_item.pitch_deg > PITCH_UP_LIM) begin
      slope_new = SLOPE_UP;
    end else if (in_item.pitch_deg < PITCH_DN_LIM) begin
      slope_new = SLOPE_DOWN;
    end else if (in_item.roll_deg > ROLL_HI_LIM) begin
      slope_new = SLOPE_TILT_LEFT;
    end else if (in_item.roll_deg < ROLL_LO_LIM) begin
      slope_new = SLOPE_TILT_RIGHT;
    end else begin
      slope_new = SLOPE_LEVEL;
    end
    dt_up  = in_item.now_ms - up_time_r;
    dt_lvl = in_item.now_ms - lvl_time_r;
  end

  always_comb begin
    priority if (silver_r) begin
      act_comb = ACT_RESCUE;
    end else if (slope_r == SLOPE_DOWN && crest_hit_r) begin
      act_comb = ACT_CREST;
    end else if (slope_r == SLOPE_UP && recov_hit_r && cnt_r >= CNT_W'(RECOVERY_BLACKS)) begin
      act_comb = ACT_RECOVERY;
    end else begin
      act_comb = ACT_DRIVE;
    end
  end

  // line error and speed from the centroid quotient, edge sensors and junction test
  always_comb begin
    wsum_abs = wsum_r[WSUM_W-1] ? QUO_W'(-wsum_r) : QUO_W'(wsum_r);
    edge_l   = mask_r[0] | mask_r[1];
    edge_r   = mask_r[SENSORS-2] | mask_r[SENSORS-1];
    junction = (wsum_abs > QUO_W'(JUNCTION_THR)) && front_r;
    err_div  = wsum_r[WSUM_W-1] ? -ERR_W'(quotient) : ERR_W'(quotient);
    err_fin  = (cnt_r == '0) ? '0 : err_div;
    if (edge_l) begin
      err_fin = -ERR_W'(EDGE_ERR);
    end
    if (edge_r) begin
      err_fin = ERR_W'(EDGE_ERR);
    end
    if (edge_l && edge_r) begin
      err_fin = '0;
    end
    if (junction) begin
      err_fin = '0;
    end
    err_abs = err_fin[ERR_W-1] ? ERR_W'(-err_fin) : ERR_W'(err_fin);

    if (junction || slope_r != SLOPE_LEVEL) begin
      speed_fin = cfg.slow_speed;
    end else begin
      speed_fin = cfg.normal_speed;
    end
    if (err_abs <= ERR_W'(1) && slope_r != SLOPE_DOWN) begin
      speed_fin = cfg.fast_speed;
    end else if (err_abs >= ERR_W'(2)) begin
      speed_fin = cfg.slow_speed;
    end
  end

  always_comb begin
    sum_new  = clamp_sum({err_sum_r[SUM_W-1], err_sum_r}
                         + {{(SUM_W+1-ERR_W){err_r[ERR_W-1]}}, err_r});
    err_diff = {err_r[ERR_W-1], err_r} - {prev_err_r[ERR_W-1], prev_err_r};
  end

  // turn, downhill quartering toward zero, drive split
  always_comb begin
    acc_bias = acc + (acc[PID_W-1] ? PID_W'((1 << DOWNHILL_SHIFT) - 1) : '0);
    turn     = (slope_r == SLOPE_DOWN) ? (acc_bias >>> DOWNHILL_SHIFT) : acc;
    turn_ext   = {turn[PID_W-1], turn};
    speed_ext  = {{(PID_W+1-SPEED_W){1'b0}}, speed_r};
    left_full  = speed_ext + turn_ext;
    right_full = speed_ext - turn_ext;

    result.action        = act_r;
    result.slope_status  = slope_r;
    result.slope_changed = changed_r;
    if (act_r == ACT_DRIVE) begin
      result.left_drive  = clamp_drive(left_full);
      result.right_drive = clamp_drive(right_full);
    end else begin
      result.left_drive  = '0;
      result.right_drive = '0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (idx_r == IDX_W'(SENSORS - 1)) state_nxt = ST_CHOOSE;
      ST_CHOOSE: state_nxt = (act_comb == ACT_DRIVE) ? ST_DIV : ST_FINISH;
      ST_DIV:    if (div_done) state_nxt = ST_MAC_P;
      ST_MAC_P:  state_nxt = ST_MAC_I;
      ST_MAC_I:  state_nxt = ST_MAC_D;
      ST_MAC_D:  state_nxt = ST_FINISH;
      ST_FINISH: if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    mac_ctl     = '0;
    unique case (state_r)
      ST_IDLE:   in_ready = rst_n;
      ST_CHOOSE: div_start = (act_comb == ACT_DRIVE);
      ST_MAC_P: begin
        mac_ctl.en      = 1'b1;
        mac_ctl.clr     = 1'b1;
        mac_ctl.gain    = cfg.prop_gain;
        mac_ctl.operand = {{(SUM_W-ERR_W){err_r[ERR_W-1]}}, err_r};
      end
      ST_MAC_I: begin
        mac_ctl.en      = 1'b1;
        mac_ctl.gain    = cfg.integral_gain;
        mac_ctl.operand = sum_new;
      end
      ST_MAC_D: begin
        mac_ctl.en      = 1'b1;
        mac_ctl.gain    = cfg.deriv_gain;
        mac_ctl.operand = {{(SUM_W-DIFF_W){err_diff[DIFF_W-1]}}, err_diff};
      end
      ST_FINISH: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slope_r     <= SLOPE_LEVEL;
      up_time_r   <= '0;
      lvl_time_r  <= '0;
      err_sum_r   <= '0;
      prev_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        slope_r <= slope_new;
        if (slope_new == SLOPE_UP) begin
          up_time_r <= in_item.now_ms;
        end
        if (slope_new == SLOPE_LEVEL) begin
          lvl_time_r <= in_item.now_ms;
        end
      end
      if (state_r == ST_MAC_D) begin
        err_sum_r  <= sum_new;
        prev_err_r <= err_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mask_r      <= in_item.black_mask;
      silver_r    <= in_item.silver_seen;
      front_r     <= in_item.front_black;
      changed_r   <= (slope_new != slope_r);
      crest_hit_r <= dt_up < TIME_W'(cfg.crest_window_ms);
      recov_hit_r <= dt_lvl < TIME_W'(cfg.recovery_window_ms);
      idx_r       <= '0;
      wsum_r      <= '0;
      cnt_r       <= '0;
    end
    if (state_r == ST_SCAN) begin
      if (mask_r[idx_r]) begin
        wsum_r <= wsum_r + WSUM_W'(sensor_weight(idx_r));
        cnt_r  <= cnt_r + 1'b1;
      end
      idx_r <= idx_r + 1'b1;
    end
    if (state_r == ST_CHOOSE) begin
      act_r <= act_comb;
    end
    if (state_r == ST_DIV && div_done) begin
      err_r   <= err_fin;
      speed_r <= speed_fin;
    end
    if (out_load) begin
      out_r <= result;
    end
  end

  lfsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (wsum_abs),
    .divisor  (cnt_r),
    .quotient (quotient),
    .done     (div_done)
  );

  lfsc_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .acc (acc)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

// ===== hdl/lfsc_chk.sv =====
`default_nettype none
`include "line_follow_steering_controller_macros.svh"
module lfsc_chk (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  in_valid,
  input wire logic                                  in_ready,
  input wire logic                                  out_valid,
  input wire logic                                  out_ready,
  input wire logic [lfsc_pkg::ACT_W-1:0]            out_action,
  input wire logic signed [lfsc_pkg::DRIVE_W-1:0]   out_left,
  input wire logic signed [lfsc_pkg::DRIVE_W-1:0]   out_right,
  input wire logic [lfsc_pkg::SLOPE_W-1:0]          out_slope
);
  import lfsc_pkg::*;

  // a pending result beat stays offered
  `LFSC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
  // one frame at a time: ready drops right after a frame is taken
  `LFSC_ASSERT_NXT(a_one_frame, in_valid && in_ready, !in_ready, "frame taken while busy")
  // every non-drive action stops both motors
  `LFSC_ASSERT_IMP(a_stop_zero, out_valid && out_action != ACT_DRIVE, out_left == '0 && out_right == '0, "drive not zero on stop")
  // crest pause only downhill, recovery only uphill
  `LFSC_ASSERT_IMP(a_act_slope, out_valid && (out_action == ACT_CREST || out_action == ACT_RECOVERY), (out_action == ACT_CREST && out_slope == SLOPE_DOWN) || (out_action == ACT_RECOVERY && out_slope == SLOPE_UP), "action inconsistent with slope")

endmodule

bind line_follow_steering_controller lfsc_chk u_lfsc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_action (out_ch.action),
  .out_left   (out_ch.left_drive),
  .out_right  (out_ch.right_drive),
  .out_slope  (out_ch.slope_status)
);
`default_nettype wire

// ===== bench/steering_checker.sv =====
`timescale 1ns / 100ps
module steering_checker
  import lfsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lfsc_in_if                         in_ch,
  lfsc_out_if                        out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending
);

  localparam int LANE_WT [SENSORS] = '{-8, -6, -5, -4, -3, -2, -1, 0, 1, 2, 3, 4, 5, 6, 8};
  localparam int PITCH_LIM        = 10;
  localparam int ROLL_LIM         = 6;
  localparam int DOWN_DIV         = 4;
  localparam int LEFT_EDGE_LAST   = 1;
  localparam int RIGHT_EDGE_FIRST = 13;

  cfg_t              regs;
  slope_t            slope_q;
  logic [TIME_W-1:0] uphill_ms;
  logic [TIME_W-1:0] level_ms;
  int                err_acc;
  int                err_last;
  out_item_t         cmd_due [$];

  function automatic int clip(input int v, input int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // updates the slope and pid state, returns the command for this frame
  function automatic out_item_t steer_frame(input in_item_t f);
    out_item_t         r;
    slope_t            was;
    logic [TIME_W-1:0] since_up;
    logic [TIME_W-1:0] since_level;
    int                pitch, roll, wsum, lit, err, spd, pid, turn;
    int                kp, ki, kd, left, right;
    bit                edge_l, edge_r;
    was    = slope_q;
    pitch  = f.pitch_deg;
    roll   = f.roll_deg;
    wsum   = 0;
    lit    = 0;
    edge_l = 1'b0;
    edge_r = 1'b0;
    left   = 0;
    right  = 0;

    if (pitch > PITCH_LIM) begin
      slope_q   = SLOPE_UP;
      uphill_ms = f.now_ms;
    end else if (pitch < -PITCH_LIM) begin
      slope_q = SLOPE_DOWN;
    end else if (roll > ROLL_LIM) begin
      slope_q = SLOPE_TILT_LEFT;
    end else if (roll < -ROLL_LIM) begin
      slope_q = SLOPE_TILT_RIGHT;
    end else begin
      slope_q  = SLOPE_LEVEL;
      level_ms = f.now_ms;
    end

    for (int i = 0; i < SENSORS; i++) begin
      if (f.black_mask[i]) begin
        wsum += LANE_WT[i];
        lit++;
        if (i <= LEFT_EDGE_LAST) edge_l = 1'b1;
        if (i >= RIGHT_EDGE_FIRST) edge_r = 1'b1;
      end
    end

    since_up    = f.now_ms - uphill_ms;
    since_level = f.now_ms - level_ms;
    r.action    = ACT_DRIVE;
    if (f.silver_seen) begin
      r.action = ACT_RESCUE;
    end else if (slope_q == SLOPE_DOWN && since_up < TIME_W'(regs.crest_window_ms)) begin
      r.action = ACT_CREST;
    end else if (slope_q == SLOPE_UP && since_level < TIME_W'(regs.recovery_window_ms)
                 && lit >= RECOVERY_BLACKS) begin
      r.action = ACT_RECOVERY;
    end else begin
      err = 0;
      if (lit > 0) err = wsum / lit;
      if (edge_l) err = LANE_WT[0];
      if (edge_r) err = LANE_WT[SENSORS-1];
      if (edge_l && edge_r) err = 0;

      if ((wsum > JUNCTION_THR || wsum < -JUNCTION_THR) && f.front_black) begin
        err = 0;
        spd = regs.slow_speed;
      end else if (slope_q != SLOPE_LEVEL) begin
        spd = regs.slow_speed;
      end else begin
        spd = regs.normal_speed;
      end
      if (err >= -1 && err <= 1 && slope_q != SLOPE_DOWN) begin
        spd = regs.fast_speed;
      end else if (err >= 2 || err <= -2) begin
        spd = regs.slow_speed;
      end

      kp       = regs.prop_gain;
      ki       = regs.integral_gain;
      kd       = regs.deriv_gain;
      err_acc  = clip(err_acc + err, SUM_LIMIT);
      pid      = kp * err + ki * err_acc + kd * (err - err_last);
      err_last = err;
      // integer divide truncates toward zero on the way downhill
      turn     = (slope_q == SLOPE_DOWN) ? pid / DOWN_DIV : pid;
      left     = clip(spd + turn, DRIVE_LIMIT);
      right    = clip(spd - turn, DRIVE_LIMIT);
    end

    r.left_drive    = left[DRIVE_W-1:0];
    r.right_drive   = right[DRIVE_W-1:0];
    r.slope_status  = slope_q;
    r.slope_changed = (slope_q != was);
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want, got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    in_item_t  frame;
    out_item_t want;
    if (!rst_n) begin
      regs = '{RST_PROP_GAIN, RST_INT_GAIN, RST_DERIV_GAIN, RST_NORMAL_SPD,
               RST_FAST_SPD, RST_SLOW_SPD, RST_CREST_WIN, RST_RECOV_WIN};
      slope_q    = SLOPE_LEVEL;
      uphill_ms  = '0;
      level_ms   = '0;
      err_acc    = 0;
      err_last   = 0;
      fail_count = 0;
      cmd_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (cmd_due.size() == 0) begin
          $display("%0t: result beat expected none, got action %0d left %0d right %0d slope %0d",
                   $time, out_ch.action, out_ch.left_drive, out_ch.right_drive,
                   out_ch.slope_status);
          fail_count++;
        end else begin
          want = cmd_due.pop_front();
          check_field("action", want.action, out_ch.action);
          check_field("left_drive", want.left_drive, out_ch.left_drive);
          check_field("right_drive", want.right_drive, out_ch.right_drive);
          check_field("slope_status", want.slope_status, out_ch.slope_status);
          check_field("slope_changed", want.slope_changed, out_ch.slope_changed);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        frame.black_mask  = in_ch.black_mask;
        frame.silver_seen = in_ch.silver_seen;
        frame.front_black = in_ch.front_black;
        frame.pitch_deg   = in_ch.pitch_deg;
        frame.roll_deg    = in_ch.roll_deg;
        frame.now_ms      = in_ch.now_ms;
        cmd_due.push_back(steer_frame(frame));
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PROP_GAIN:  regs.prop_gain          = cfg_wdata[GAIN_W-1:0];
          REG_INT_GAIN:   regs.integral_gain      = cfg_wdata[GAIN_W-1:0];
          REG_DERIV_GAIN: regs.deriv_gain         = cfg_wdata[GAIN_W-1:0];
          REG_NORMAL_SPD: regs.normal_speed       = cfg_wdata[SPEED_W-1:0];
          REG_FAST_SPD:   regs.fast_speed         = cfg_wdata[SPEED_W-1:0];
          REG_SLOW_SPD:   regs.slow_speed         = cfg_wdata[SPEED_W-1:0];
          REG_CREST_WIN:  regs.crest_window_ms    = cfg_wdata[WIN_W-1:0];
          REG_RECOV_WIN:  regs.recovery_window_ms = cfg_wdata[WIN_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= cmd_due.size();
  end

endmodule

// ===== bench/line_follow_steering_controller_tb.sv =====
`timescale 1ns / 100ps
module line_follow_steering_controller_tb;
  import lfsc_pkg::*;

  typedef enum {POSE_LEVEL, POSE_CLIMB, POSE_DESCEND, POSE_LEAN_LEFT, POSE_LEAN_RIGHT,
                POSE_WILD} pose_t;
  typedef enum {DRIFT_NONE, DRIFT_LEFT, DRIFT_RIGHT} drift_t;

  localparam int HOLD_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;

  bit                    calm = 1'b0;
  bit                    hold_req = 1'b0;
  pose_t                 pose = POSE_LEVEL;
  logic [TIME_W-1:0]     ms_q = '0;

  lfsc_in_if  in_ch ();
  lfsc_out_if out_ch ();

  line_follow_steering_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  steering_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  task automatic send_frame(input in_item_t f);
    in_ch.valid       <= 1'b1;
    in_ch.black_mask  <= f.black_mask;
    in_ch.silver_seen <= f.silver_seen;
    in_ch.front_black <= f.front_black;
    in_ch.pitch_deg   <= f.pitch_deg;
    in_ch.roll_deg    <= f.roll_deg;
    in_ch.now_ms      <= f.now_ms;
    do @(posedge clk); while (!in_ch.ready);
    if (!calm && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  task automatic send_at(input logic [SENSORS-1:0] mask, input bit silver, input bit front,
                         input int pitch, input int roll, input logic [TIME_W-1:0] now);
    in_item_t f;
    f.black_mask  = mask;
    f.silver_seen = silver;
    f.front_black = front;
    f.pitch_deg   = pitch[ANGLE_W-1:0];
    f.roll_deg    = roll[ANGLE_W-1:0];
    f.now_ms      = now;
    send_frame(f);
  endtask

  // wait until every command has come back and the block has gone quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val, input int w);
    logic [CFG_DATA_W-1:0] junk;
    // bits above the register width must be dropped
    junk = CFG_DATA_W'($urandom);
    junk = junk << w;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val | junk;
    @(posedge clk);
  endtask

  task automatic load_regs(input cfg_t c);
    write_reg(REG_PROP_GAIN, CFG_DATA_W'(c.prop_gain), GAIN_W);
    write_reg(REG_INT_GAIN, CFG_DATA_W'(c.integral_gain), GAIN_W);
    write_reg(REG_DERIV_GAIN, CFG_DATA_W'(c.deriv_gain), GAIN_W);
    write_reg(REG_NORMAL_SPD, CFG_DATA_W'(c.normal_speed), SPEED_W);
    write_reg(REG_FAST_SPD, CFG_DATA_W'(c.fast_speed), SPEED_W);
    write_reg(REG_SLOW_SPD, CFG_DATA_W'(c.slow_speed), SPEED_W);
    write_reg(REG_CREST_WIN, CFG_DATA_W'(c.crest_window_ms), WIN_W);
    write_reg(REG_RECOV_WIN, CFG_DATA_W'(c.recovery_window_ms), WIN_W);
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t random_regs();
    cfg_t c;
    c.prop_gain          = GAIN_W'($urandom_range(63));
    c.integral_gain      = GAIN_W'($urandom_range(63));
    c.deriv_gain         = GAIN_W'($urandom_range(63));
    c.normal_speed       = SPEED_W'($urandom_range(127));
    c.fast_speed         = SPEED_W'($urandom_range(127));
    c.slow_speed         = SPEED_W'($urandom_range(127));
    c.crest_window_ms    = WIN_W'($urandom_range(4000));
    c.recovery_window_ms = WIN_W'($urandom_range(4000));
    if ($urandom_range(3) == 0) c.crest_window_ms = WIN_W'($urandom);
    return c;
  endfunction

  function automatic logic [SENSORS-1:0] pick_mask(input drift_t drift);
    int                 len, pos;
    logic [SENSORS-1:0] m;
    if (drift == DRIFT_RIGHT && $urandom_range(99) < 95) begin
      return (15'h1 << $urandom_range(13, 14)) | (SENSORS'($urandom) & 15'h1F00);
    end
    if (drift == DRIFT_LEFT && $urandom_range(99) < 95) begin
      return (15'h1 << $urandom_range(0, 1)) | (SENSORS'($urandom) & 15'h007C);
    end
    case ($urandom_range(9))
      0: m = '0;
      1: m = '1;
      2: m = 15'h1 << $urandom_range(14);
      6: m = SENSORS'($urandom);
      7: m = (SENSORS'($urandom) & 15'h6003) | (15'h1 << $urandom_range(2, 12));
      8, 9: begin
        // wide run: junction and recovery material
        len = $urandom_range(5, 9);
        pos = $urandom_range(0, SENSORS - len);
        m   = ((15'h1 << len) - 15'h1) << pos;
      end
      default: begin
        // narrow run, like a real line under the array
        len = $urandom_range(1, 4);
        pos = $urandom_range(0, SENSORS - len);
        m   = ((15'h1 << len) - 15'h1) << pos;
      end
    endcase
    return m;
  endfunction

  task automatic play_random(input int count, input drift_t drift);
    in_item_t f;
    int       pitch, roll, r;
    repeat (count) begin
      // poses persist for a while so climbs are followed by descents
      if ($urandom_range(99) < 30) begin
        r = $urandom_range(99);
        if (r < 35)      pose = POSE_LEVEL;
        else if (r < 55) pose = POSE_CLIMB;
        else if (r < 75) pose = POSE_DESCEND;
        else if (r < 84) pose = POSE_LEAN_LEFT;
        else if (r < 93) pose = POSE_LEAN_RIGHT;
        else             pose = POSE_WILD;
      end
      case (pose)
        POSE_LEVEL: begin
          pitch = int'($urandom_range(20)) - 10;
          roll  = int'($urandom_range(12)) - 6;
        end
        POSE_CLIMB: begin
          pitch = ($urandom_range(9) == 0) ? int'($urandom_range(255, 11))
                                           : 11 + int'($urandom_range(40));
          roll  = int'($urandom_range(60)) - 30;
        end
        POSE_DESCEND: begin
          pitch = ($urandom_range(9) == 0) ? -int'($urandom_range(256, 11))
                                           : -11 - int'($urandom_range(40));
          roll  = int'($urandom_range(60)) - 30;
        end
        POSE_LEAN_LEFT: begin
          pitch = int'($urandom_range(20)) - 10;
          roll  = 7 + int'($urandom_range(50));
        end
        POSE_LEAN_RIGHT: begin
          pitch = int'($urandom_range(20)) - 10;
          roll  = -7 - int'($urandom_range(50));
        end
        default: begin
          pitch = int'($urandom_range(511)) - 256;
          roll  = int'($urandom_range(511)) - 256;
        end
      endcase
      r = $urandom_range(99);
      if (r < 85)      ms_q += $urandom_range(600);
      else if (r < 95) ms_q += $urandom_range(6000);
      else             ms_q = $urandom;
      f.black_mask  = pick_mask(drift);
      f.silver_seen = ($urandom_range(99) < 4);
      f.front_black = 1'($urandom_range(1));
      f.pitch_deg   = pitch[ANGLE_W-1:0];
      f.roll_deg    = roll[ANGLE_W-1:0];
      f.now_ms      = ms_q;
      send_frame(f);
    end
  endtask

  // receiver holds off while frames keep coming, so the input backs up
  task automatic pile_up();
    calm     = 1'b1;
    hold_req = 1'b1;
    play_random(12, DRIFT_NONE);
    calm     = 1'b0;
  endtask

  initial begin : frame_source
    cfg_t sat;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_PROP_GAIN;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.black_mask  <= '0;
    in_ch.silver_seen <= 1'b0;
    in_ch.front_black <= 1'b0;
    in_ch.pitch_deg   <= '0;
    in_ch.roll_deg    <= '0;
    in_ch.now_ms      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults
    send_at(15'h0000, 0, 0,    0,    0, 32'd1000);  // no line
    send_at(15'h7FFF, 0, 1,    0,    0, 32'd1010);  // all black, both edges
    send_at(15'h0001, 0, 0,    0,    0, 32'd1020);
    send_at(15'h0002, 0, 0,    0,    0, 32'd1030);
    send_at(15'h4000, 0, 0,    0,    0, 32'd1040);
    send_at(15'h2000, 0, 0,    0,    0, 32'd1050);
    send_at(15'h0080, 0, 1,   10,    6, 32'd1060);  // still level at the thresholds
    send_at(15'h000C, 0, 0,  -10,   -6, 32'd1070);  // centroid truncates toward zero
    send_at(15'h0300, 0, 0,    0,    0, 32'd1080);
    send_at(15'h7E00, 0, 1,    0,    0, 32'd1090);  // junction
    send_at(15'h7E00, 0, 0,    0,    0, 32'd1100);
    send_at(15'h0F0F, 1, 1,    0,    0, 32'd1110);  // silver
    send_at(15'h0000, 0, 0,    0,    7, 32'd1120);
    send_at(15'h0010, 0, 0,    0,   -7, 32'd1130);
    send_at(15'h0000, 0, 0,   11,    0, 32'd2000);
    send_at(15'h0040, 0, 0,  -11,    0, 32'd2500);  // crest
    send_at(15'h0400, 0, 0,  -11,    0, 32'd4000);  // window just missed, quartered turn
    send_at(15'h0000, 0, 0,    0,    0, 32'd5000);
    send_at(15'h01F0, 0, 0,   20,    0, 32'd5100);  // recovery
    send_at(15'h00F0, 0, 0,   20,    0, 32'd5200);  // too few blacks
    send_at(15'h01F0, 0, 0,   20,    0, 32'd6500);  // window just missed
    send_at(15'h0000, 1, 0,  255, -256, 32'd6600);
    send_at(15'h0000, 0, 0, -256,  255, 32'd6700);
    send_at(15'h0000, 0, 0,    0,  255, 32'd6800);
    send_at(15'h0000, 0, 0,    0, -256, 32'd6900);
    send_at(15'h0000, 0, 0,   11,    0, 32'hFFFF_FFF0);
    send_at(15'h0001, 0, 0,  -11,    0, 32'd5);      // time wraps inside the window

    drain();
    load_regs('{6'd63, 6'd63, 6'd63, 7'd127, 7'd127, 7'd127, 16'hFFFF, 16'hFFFF});
    send_at(15'h4000, 0, 0,    0,    0, 32'd100);
    send_at(15'h0001, 0, 0,  -30,    0, 32'd200);
    send_at(15'h0001, 0, 0,    0,    0, 32'd300);
    ms_q = 32'd300;
    pile_up();
    play_random(150, DRIFT_NONE);

    drain();
    load_regs('0);
    calm = 1'b1;
    play_random(80, DRIFT_NONE);
    calm = 1'b0;
    play_random(70, DRIFT_NONE);

    // long one-sided drift drives the error sum into its limit
    drain();
    sat = '{6'd3, 6'd1, 6'd5, 7'd50, 7'd70, 7'd30, 16'd0, 16'd0};
    load_regs(sat);
    play_random(650, DRIFT_RIGHT);
    play_random(100, DRIFT_LEFT);

    for (int k = 0; k < 4; k++) begin
      drain();
      load_regs(random_regs());
      if (k == 1) pile_up();
      play_random(125, (k == 2) ? DRIFT_LEFT : DRIFT_NONE);
    end

    drain();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== line_follow_steering_controller.f =====
+incdir+hdl
hdl/lfsc_pkg.sv
hdl/lfsc_if.sv
hdl/lfsc_div.sv
hdl/lfsc_mac.sv
hdl/lfsc_seq.sv
hdl/line_follow_steering_controller.sv
hdl/lfsc_chk.sv
bench/steering_checker.sv
bench/line_follow_steering_controller_tb.sv
